>>> rtl/lpr_pkg.sv
// Shared widths, constants and controller/datapath handshake types for the LRU page block.
package lpr_pkg;

    localparam int PAGE_W = 16;   // page_number / evicted_page field width
    localparam int IDX_W  = 5;    // frame_index field width
    localparam int CNT_W  = 16;   // miss counter width
    localparam int AGE_W  = 16;   // per-frame age width
    localparam int CFG_W  = 6;    // frames_in_use register width

    localparam logic [CFG_W-1:0] CFG_RESET = 6'd4;

    localparam int OUT_TUSER_W = 2;
    localparam int OUT_BITS    = IDX_W + PAGE_W + CNT_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD     = OUT_TDATA_W - OUT_BITS;

    // tuser bit positions on the result side
    localparam int TUSER_HIT = 0;
    localparam int TUSER_EVV = 1;

    // controller -> datapath
    typedef struct packed {
        logic load_page;    // capture the incoming reference
        logic load_lookup;  // register hit / free-frame result
        logic load_victim;  // register oldest frame from the age tree
        logic commit;       // update frames, ages, counter and result register
    } lpr_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_search;  // miss with every active frame full
        logic out_free;     // result register can take a beat this cycle
    } lpr_sts_t;

endpackage

>>> rtl/lru_page_replacement.sv
// Top level of the LRU page replacement block: controller, datapath and checks.
//
// Usage
//   s_axis: one page reference per beat, tdata[15:0] = page_number
//           (only the low PAGE_BITS bits take part in the compare).
//   m_axis: one result beat per reference, in order.
//   cfg:    frames_in_use write (cfg_data[5:0]); always ready. Write it
//           only while no reference is in flight. 0 acts as 1, values
//           above MAX_FRAMES act as MAX_FRAMES.
// Sequence
//   A hit, or a miss that finds an empty frame: the reference is taken,
//   compared against all frames at once, and committed once the result
//   register is free; no new reference is taken until that commit.
//   A miss with all active frames full waits on the registered oldest-frame
//   tree, log2(MAX_FRAMES) levels deep, before its commit.
//   Result beats appear the cycle after commit.
// Reset: all frames invalid, ages and miss count zero, frames_in_use = 4.
// Backpressure: the result register holds one beat; the next reference is
//   still taken and looked up, and its commit waits until m_axis_tready frees the slot.
module lru_page_replacement #(
    parameter int MAX_FRAMES = 32,
    parameter int PAGE_BITS  = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // config write
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lpr_pkg::CFG_W-1:0]       cfg_data,     // frames_in_use
    // reference stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [lpr_pkg::PAGE_W-1:0]      s_axis_tdata, // [15:0] page_number
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [4:0] frame_index, [20:5] evicted_page, [36:21] miss_total, [39:37] zero
    output logic [lpr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] hit, [1] evicted_valid
    output logic [lpr_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

    localparam int LEVELS = $clog2(MAX_FRAMES);

    lpr_pkg::lpr_cmd_t cmd;
    lpr_pkg::lpr_sts_t sts;

    assign cfg_ready = 1'b1;

    lpr_ctrl #(
        .LEVELS (LEVELS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lpr_datapath #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_valid),
        .cfg_data  (cfg_data),
        .in_page   (s_axis_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_tdata (m_axis_tdata),
        .out_tuser (m_axis_tuser)
    );

    // commit never overwrites a beat the receiver has not taken
    a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!m_axis_tvalid || m_axis_tready))
        else $error("commit while result register full");

    // a taken reference blocks the input until its commit
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_page |=> !s_axis_tready)
        else $error("second reference accepted while one is in flight");

    // an eviction only happens on a miss
    a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[lpr_pkg::TUSER_HIT]
                            && m_axis_tuser[lpr_pkg::TUSER_EVV]))
        else $error("hit reported with an eviction");

    // a commit is always followed by a result beat
    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> m_axis_tvalid)
        else $error("commit produced no result beat");

endmodule

>>> rtl/lpr_ctrl.sv
// Sequencing state machine for one page reference at a time.
module lpr_ctrl #(
    parameter int LEVELS = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lpr_pkg::lpr_sts_t sts,
    output lpr_pkg::lpr_cmd_t cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LOOKUP = 2'd1;
    localparam logic [1:0] S_SEARCH = 2'd2;
    localparam logic [1:0] S_COMMIT = 2'd3;

    localparam int CW = $clog2(LEVELS + 1);

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_page = 1'b1;
                    state_next    = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                cmd.load_lookup = 1'b1;
                cnt_next        = '0;
                state_next      = sts.need_search ? S_SEARCH : S_COMMIT;
            end
            S_SEARCH:
            begin
                // wait for the registered age tree to settle
                if (cnt_reg == CW'(LEVELS - 1))
                begin
                    cmd.load_victim = 1'b1;
                    state_next      = S_COMMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_COMMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

>>> rtl/lpr_datapath.sv
// Frame table, parallel tag compare, registered oldest-frame tree and result register.
module lpr_datapath #(
    parameter int MAX_FRAMES = 32,
    parameter int PAGE_BITS  = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr,
    input  logic [lpr_pkg::CFG_W-1:0]       cfg_data,
    input  logic [lpr_pkg::PAGE_W-1:0]      in_page,
    input  lpr_pkg::lpr_cmd_t               cmd,
    output lpr_pkg::lpr_sts_t               sts,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [lpr_pkg::OUT_TDATA_W-1:0] out_tdata,
    output logic [lpr_pkg::OUT_TUSER_W-1:0] out_tuser
);

    localparam int FW = $clog2(MAX_FRAMES);
    localparam int P  = 1 << FW;
    localparam int CW = lpr_pkg::CFG_W;
    localparam int AW = lpr_pkg::AGE_W;

    // configuration and frame state
    logic [CW-1:0]        cfg_reg;
    logic [PAGE_BITS-1:0] frame_page_reg [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] valid_reg;
    logic [AW-1:0]        age_reg [MAX_FRAMES];
    logic [lpr_pkg::CNT_W-1:0] miss_reg;

    // per-item working registers
    logic [PAGE_BITS-1:0] page_reg;
    logic                 hit_reg;
    logic                 evict_reg;
    logic [FW-1:0]        sel_reg;

    // result register
    logic                        out_valid_reg;
    logic                        out_hit_reg;
    logic                        out_evv_reg;
    logic [lpr_pkg::IDX_W-1:0]   out_idx_reg;
    logic [lpr_pkg::PAGE_W-1:0]  out_evp_reg;
    logic [lpr_pkg::CNT_W-1:0]   out_miss_reg;

    // lookup
    logic [MAX_FRAMES-1:0] active;
    logic [MAX_FRAMES-1:0] match;
    logic [MAX_FRAMES-1:0] free;
    logic [FW-1:0]         match_idx;
    logic [FW-1:0]         free_idx;
    logic                  any_match;
    logic                  any_free;

    logic [PAGE_BITS+lpr_pkg::PAGE_W-1:0] page_ext;
    logic [lpr_pkg::PAGE_W+PAGE_BITS-1:0] evp_ext;
    logic [lpr_pkg::IDX_W+FW-1:0]         idx_ext;
    logic [lpr_pkg::CNT_W-1:0]            miss_next;

    // age tree: leaves then registered nodes (heap order, root at 1)
    logic          leaf_v [P];
    logic [AW-1:0] leaf_a [P];
    logic [FW-1:0] leaf_i [P];
    logic          tv_reg [1:P-1];
    logic [AW-1:0] ta_reg [1:P-1];
    logic [FW-1:0] ti_reg [1:P-1];
    logic          lv [1:P-1];
    logic          rv [1:P-1];
    logic [AW-1:0] la [1:P-1];
    logic [AW-1:0] ra [1:P-1];
    logic [FW-1:0] li [1:P-1];
    logic [FW-1:0] ri [1:P-1];
    logic          pick_l [1:P-1];

    assign page_ext = {{PAGE_BITS{1'b0}}, in_page};

    always_comb
    begin
        match_idx = '0;
        free_idx  = '0;
        for (int j = 0; j < MAX_FRAMES; j++)
        begin
            active[j] = (j == 0) || ((CW + 1)'(j) < {1'b0, cfg_reg});
            match[j]  = active[j] && valid_reg[j] && (frame_page_reg[j] == page_reg);
            free[j]   = active[j] && !valid_reg[j];
        end
        // lowest index wins
        for (int j = MAX_FRAMES - 1; j >= 0; j--)
        begin
            if (match[j])
            begin
                match_idx = FW'(j);
            end
            if (free[j])
            begin
                free_idx = FW'(j);
            end
        end
    end

    assign any_match = |match;
    assign any_free  = |free;

    assign sts.need_search = !any_match && !any_free;
    assign sts.out_free    = !out_valid_reg || out_ready;

    genvar k;
    generate
        for (k = 0; k < P; k++)
        begin : g_leaf
            if (k < MAX_FRAMES)
            begin : g_real
                assign leaf_v[k] = active[k];
                assign leaf_a[k] = age_reg[k];
                assign leaf_i[k] = FW'(k);
            end
            else
            begin : g_pad
                assign leaf_v[k] = 1'b0;
                assign leaf_a[k] = '0;
                assign leaf_i[k] = '0;
            end
        end
        for (k = 1; k < P; k++)
        begin : g_node
            if (2 * k >= P)
            begin : g_from_leaf
                assign lv[k] = leaf_v[2*k-P];
                assign la[k] = leaf_a[2*k-P];
                assign li[k] = leaf_i[2*k-P];
                assign rv[k] = leaf_v[2*k+1-P];
                assign ra[k] = leaf_a[2*k+1-P];
                assign ri[k] = leaf_i[2*k+1-P];
            end
            else
            begin : g_from_node
                assign lv[k] = tv_reg[2*k];
                assign la[k] = ta_reg[2*k];
                assign li[k] = ti_reg[2*k];
                assign rv[k] = tv_reg[2*k+1];
                assign ra[k] = ta_reg[2*k+1];
                assign ri[k] = ti_reg[2*k+1];
            end
            // greater age wins, left (lower index) on a tie
            assign pick_l[k] = lv[k] && (!rv[k] || (la[k] >= ra[k]));
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        for (int i = 1; i < P; i++)
        begin
            tv_reg[i] <= lv[i] || rv[i];
            ta_reg[i] <= pick_l[i] ? la[i] : ra[i];
            ti_reg[i] <= pick_l[i] ? li[i] : ri[i];
        end
    end

    // per-item registers and page storage (no reset)
    always_ff @(posedge clk)
    begin
        if (cmd.load_page)
        begin
            page_reg <= page_ext[PAGE_BITS-1:0];
        end
        if (cmd.load_lookup)
        begin
            hit_reg   <= any_match;
            evict_reg <= !any_match && !any_free;
            sel_reg   <= any_match ? match_idx : free_idx;
        end
        else if (cmd.load_victim)
        begin
            sel_reg <= ti_reg[1];
        end
        if (cmd.commit && !hit_reg)
        begin
            frame_page_reg[sel_reg] <= page_reg;
        end
        if (cmd.commit)
        begin
            out_hit_reg  <= hit_reg;
            out_evv_reg  <= evict_reg;
            out_idx_reg  <= idx_ext[lpr_pkg::IDX_W-1:0];
            out_evp_reg  <= evict_reg ? evp_ext[lpr_pkg::PAGE_W-1:0] : '0;
            out_miss_reg <= miss_next;
        end
    end

    assign evp_ext   = {{lpr_pkg::PAGE_W{1'b0}}, frame_page_reg[sel_reg]};
    assign idx_ext   = {{lpr_pkg::IDX_W{1'b0}}, sel_reg};
    assign miss_next = (hit_reg || (miss_reg == '1)) ? miss_reg : miss_reg + 1'b1;

    // control-relevant state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= lpr_pkg::CFG_RESET;
            valid_reg     <= '0;
            miss_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < MAX_FRAMES; j++)
            begin
                age_reg[j] <= '0;
            end
        end
        else
        begin
            if (cfg_wr)
            begin
                cfg_reg <= cfg_data;
            end
            if (cmd.commit)
            begin
                valid_reg[sel_reg] <= 1'b1;
                miss_reg           <= miss_next;
                for (int j = 0; j < MAX_FRAMES; j++)
                begin
                    if (active[j])
                    begin
                        if (FW'(j) == sel_reg)
                        begin
                            age_reg[j] <= '0;
                        end
                        else if (age_reg[j] != '1)
                        begin
                            age_reg[j] <= age_reg[j] + 1'b1;
                        end
                    end
                end
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_tdata = {{lpr_pkg::OUT_PAD{1'b0}}, out_miss_reg, out_evp_reg, out_idx_reg};
    assign out_tuser = {out_evv_reg, out_hit_reg};

endmodule

>>> tb/lru_page_replacement_tb.sv
// Self-checking testbench for the LRU page replacement block.
`timescale 1ns / 100ps

// Strategy:
//   - A scoreboard class carries its own model of the frame table: page, valid
//     and age per frame, the miss counter and the frame-count register. Each
//     accepted reference beat is run through that model, and the predicted
//     outcome is queued. Each result beat is popped and compared field by field.
//   - Stimulus runs in two parts:
//       1. directed beats at the reset frame count. These hit the page
//          extremes, fills, hits and evictions. The frame count shrinks and
//          grows back, then is set to 0 and to 63, which are out of range.
//       2. random phases, each at a frame count from a fixed list, the
//          last drawn at random. References come mostly from a window,
//          sized just above the active frame count, of a shared page pool,
//          so hits and evictions are both common; some beats are fully random.
//   - The frame count is written only when no reference is in flight: every
//     expected result has come back and a short quiet period has passed.
//   - The sender works in random bursts with random gaps. The receiver stalls
//     on a rotating mask. Both are changed per phase, and some phases run
//     with no idling at all.
module lru_page_replacement_tb;

    localparam int MAX_FRAMES   = 32;
    localparam int POOL_SIZE    = 48;
    localparam int QUIET_CYCLES = 12;         // longer than the slowest reference takes to pass through
    localparam int CYCLE_LIMIT  = 400_000;

    // Predicted outcome of one page reference
    typedef struct packed {
        logic                       hit;
        logic [lpr_pkg::IDX_W-1:0]  frame_index;
        logic                       evicted_valid;
        logic [lpr_pkg::PAGE_W-1:0] evicted_page;
        logic [lpr_pkg::CNT_W-1:0]  miss_total;
    } lookup_outcome_t;

    // Frame table model plus the queue of outcomes still owed by the block
    class lru_scoreboard;
        logic [lpr_pkg::PAGE_W-1:0] page_tab [MAX_FRAMES];
        bit                         valid_tab[MAX_FRAMES];
        logic [lpr_pkg::AGE_W-1:0]  age_tab  [MAX_FRAMES];
        logic [lpr_pkg::CNT_W-1:0]  misses;
        logic [lpr_pkg::CFG_W-1:0]  frames_cfg;
        lookup_outcome_t            outcome_q[$];
        int                         failures;
        int                         references;
        int                         hits;
        int                         evictions;

        function new();
            for (int j = 0; j < MAX_FRAMES; j++)
            begin
                page_tab[j]  = '0;
                valid_tab[j] = 1'b0;
                age_tab[j]   = '0;
            end
            misses     = '0;
            frames_cfg = lpr_pkg::CFG_RESET;
            failures   = 0;
            references = 0;
            hits       = 0;
            evictions  = 0;
        endfunction

        // 0 behaves as 1, anything above the table size as the table size
        function int active_frames();
            if (frames_cfg == 0)
                return 1;
            if (frames_cfg > MAX_FRAMES)
                return MAX_FRAMES;
            return int'(frames_cfg);
        endfunction

        function void note_reference(logic [lpr_pkg::PAGE_W-1:0] pg);
            lookup_outcome_t           o;
            int                        n;
            int                        sel;
            bit                        found_hit;
            bit                        found_spare;
            logic [lpr_pkg::AGE_W-1:0] oldest;
            o           = '0;
            n           = active_frames();
            sel         = 0;
            found_hit   = 1'b0;
            found_spare = 1'b0;
            references++;
            // lowest matching frame wins
            for (int j = 0; j < n; j++)
                if (!found_hit && valid_tab[j] && page_tab[j] == pg)
                begin
                    found_hit = 1'b1;
                    sel       = j;
                end
            if (found_hit)
                hits++;
            else
            begin
                for (int j = 0; j < n; j++)
                    if (!found_spare && !valid_tab[j])
                    begin
                        found_spare = 1'b1;
                        sel         = j;
                    end
                if (!found_spare)
                begin
                    // oldest frame, lowest index on a tie
                    oldest = age_tab[0];
                    sel    = 0;
                    for (int j = 1; j < n; j++)
                        if (age_tab[j] > oldest)
                        begin
                            oldest = age_tab[j];
                            sel    = j;
                        end
                    o.evicted_valid = 1'b1;
                    o.evicted_page  = page_tab[sel];
                    evictions++;
                end
                page_tab[sel]  = pg;
                valid_tab[sel] = 1'b1;
                if (misses != '1)
                    misses++;
            end
            for (int j = 0; j < n; j++)
                if (age_tab[j] != '1)
                    age_tab[j]++;
            age_tab[sel] = '0;
            o.hit         = found_hit;
            o.frame_index = sel[lpr_pkg::IDX_W-1:0];
            o.miss_total  = misses;
            outcome_q.push_back(o);
        endfunction

        function void check_result(logic [lpr_pkg::OUT_TUSER_W-1:0] tuser,
                                   logic [lpr_pkg::OUT_TDATA_W-1:0] tdata);
            lookup_outcome_t                 e;
            lookup_outcome_t                 a;
            logic [lpr_pkg::OUT_TDATA_W-1:0] pad;
            a.hit           = tuser[lpr_pkg::TUSER_HIT];
            a.evicted_valid = tuser[lpr_pkg::TUSER_EVV];
            a.frame_index   = tdata[lpr_pkg::IDX_W-1:0];
            a.evicted_page  = tdata[lpr_pkg::IDX_W +: lpr_pkg::PAGE_W];
            a.miss_total    = tdata[lpr_pkg::IDX_W+lpr_pkg::PAGE_W +: lpr_pkg::CNT_W];
            pad             = tdata >> lpr_pkg::OUT_BITS;
            if (outcome_q.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("%0t: unexpected beat: hit=%0b frame=%0d ev=%0b/%h misses=%0d",
                             $realtime, a.hit, a.frame_index, a.evicted_valid, a.evicted_page,
                             a.miss_total);
                return;
            end
            e = outcome_q.pop_front();
            if (a.hit !== e.hit || a.frame_index !== e.frame_index
                || a.evicted_valid !== e.evicted_valid || a.evicted_page !== e.evicted_page
                || a.miss_total !== e.miss_total || pad !== '0)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $display("%0t: mismatch: expected hit=%0b frame=%0d ev=%0b/%h misses=%0d",
                             $realtime, e.hit, e.frame_index, e.evicted_valid, e.evicted_page,
                             e.miss_total);
                    $display("    actual hit=%0b frame=%0d ev=%0b/%h misses=%0d pad=%h",
                             a.hit, a.frame_index, a.evicted_valid, a.evicted_page,
                             a.miss_total, pad);
                end
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [lpr_pkg::CFG_W-1:0]       cfg_data;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [lpr_pkg::PAGE_W-1:0]      s_axis_tdata;    // [15:0] page_number
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [lpr_pkg::OUT_TDATA_W-1:0] m_axis_tdata;    // [4:0] frame_index, [20:5] evicted_page,
                                                      // [36:21] miss_total, [39:37] zero
    logic [lpr_pkg::OUT_TUSER_W-1:0] m_axis_tuser;    // [0] hit, [1] evicted_valid

    lru_scoreboard              sb;
    logic [lpr_pkg::PAGE_W-1:0] page_pool[POOL_SIZE];

    // sender burst/gap state
    bit                tx_idle_on;
    int                burst_left;

    // receiver stall pattern: a 13-entry mask walked round and round
    logic              stall_on;
    logic [12:0]       stall_mask;
    int                stall_pos;
    int                settings_seen;
    int                cycle_count;

    lru_page_replacement #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (lpr_pkg::PAGE_W)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Result side: check a beat on each handshake, then pick the next ready from the mask.
    // Values read here are the ones that held before the edge.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata);
        m_axis_tready <= !stall_on || stall_mask[stall_pos];
        stall_pos     <= (stall_pos == 12) ? 0 : stall_pos + 1;
    end

    // One reference beat. tvalid stays high into the next beat unless a gap follows.
    task automatic send_page(input logic [lpr_pkg::PAGE_W-1:0] pg);
        s_axis_tdata  <= pg;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_reference(pg);
        if (tx_idle_on)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                burst_left    = $urandom_range(0, 15);
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 20 : 4))
                    @(posedge clk);
            end
        end
    endtask

    // Frame count write, only once every reference has drained out of the block
    task automatic set_frame_count(input logic [lpr_pkg::CFG_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (sb.outcome_q.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES)
            @(posedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.frames_cfg = value;
        cfg_valid     <= 1'b0;
        settings_seen++;
    endtask

    // New idling style for a phase: any mix of sender gaps and receiver stalls
    task automatic pick_idling();
        tx_idle_on = ($urandom_range(0, 3) != 0);
        burst_left = $urandom_range(0, 15);
        stall_on   <= ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 1) != 0)
            stall_mask <= 13'($urandom()) | 13'd1;
        else
            stall_mask <= 13'($urandom() & $urandom()) | 13'd1;   // heavy stalling
    endtask

    // timeout guard
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d results pending",
                 cycle_count, sb.outcome_q.size());
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int                         phase_frames[10];
        int                         beats;
        int                         window;
        int                         r;
        logic [lpr_pkg::PAGE_W-1:0] pg;

        sb            = new();
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        stall_on      = 1'b0;
        stall_mask    = '1;
        stall_pos     = 0;
        tx_idle_on    = 1'b0;
        burst_left    = 0;
        settings_seen = 1;   // reset value counts as the first setting

        page_pool[0] = '0;
        page_pool[1] = '1;
        for (int k = 2; k < POOL_SIZE; k++)
            page_pool[k] = lpr_pkg::PAGE_W'($urandom());

        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed: reset frame count of 4 ----
        pick_idling();
        send_page(16'h0000);        // cold miss, lowest page
        send_page(16'hFFFF);        // cold miss, highest page
        send_page(16'h0000);        // hit
        send_page(16'h1234);
        send_page(16'h8000);        // all four frames now full
        send_page(16'h5555);        // eviction of the oldest frame
        send_page(16'hFFFF);
        send_page(16'h1234);
        send_page(16'h0001);
        send_page(16'hAAAA);
        // shrink: upper frames keep their pages but must not match or age
        set_frame_count(6'd2);
        send_page(16'h1234);
        send_page(16'h8000);
        send_page(16'h0001);
        // grow back: upper frames take part again with their old ages
        set_frame_count(6'd4);
        send_page(16'h1234);
        send_page(16'hAAAA);
        send_page(16'h5555);
        send_page(16'h7FFF);
        // zero acts as one frame
        set_frame_count(6'd0);
        send_page(16'h0000);
        send_page(16'h0000);
        send_page(16'h7FFF);
        // all ones acts as the full table
        set_frame_count(6'd63);
        send_page(16'hFFFF);
        send_page(16'h1234);
        send_page(16'h0001);

        // random phases, one per entry of phase_frames
        phase_frames = '{1, 0, 2, 32, 5, 33, 63, 7, 17, 0};
        phase_frames[9] = $urandom_range(0, 63);
        foreach (phase_frames[p])
        begin
            set_frame_count(lpr_pkg::CFG_W'(phase_frames[p]));
            pick_idling();
            window = sb.active_frames() + 3;
            if (window > POOL_SIZE)
                window = POOL_SIZE;
            beats = $urandom_range(75, 95);
            repeat (beats)
            begin
                r = $urandom_range(0, 99);
                if (r < 78)
                    pg = page_pool[$urandom_range(0, window - 1)];
                else if (r < 90)
                    pg = lpr_pkg::PAGE_W'($urandom());
                else
                    pg = page_pool[$urandom_range(0, POOL_SIZE - 1)];
                send_page(pg);
            end
        end

        // ---- drain ----
        s_axis_tvalid <= 1'b0;
        while (sb.outcome_q.size() != 0)
            @(posedge clk);
        repeat (4 * QUIET_CYCLES)
            @(posedge clk);

        $display("%0d references over %0d frame-count settings: %0d hits, %0d evictions",
                 sb.references, settings_seen, sb.hits, sb.evictions);
        $display("fills, shrink/grow and out-of-range counts covered; %0d mismatches, %0d owed",
                 sb.failures, sb.outcome_q.size());
        if (sb.failures == 0 && sb.outcome_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
